### rtl/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg
// Shared types, constants and the modulo-255 fold used by the Fletcher
// checksum insertion pipeline.
// ----------------------------------------------------------------------------
package fci_pkg;

   // Fletcher modulus and twice the modulus
   localparam int unsigned MOD_FL  = 255;
   localparam int unsigned TWO_MOD = 510;

   // Default width of the byte position counter
   localparam int unsigned LENGTH_BITS_DEF = 16;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 16;

   // Packed stream widths
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 40;

   // One accepted packet byte with its side fields
   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic                last_byte;
      logic [OFFSET_W-1:0] check_offset;
      logic                validate_only;
   } fci_item_type;

   // Packet summary handed from the accumulator to the check byte stage
   typedef struct packed {
      logic [BYTE_W-1:0] sum_first;
      logic [BYTE_W-1:0] sum_second;
      logic [BYTE_W-1:0] span;        // (last position - offset) mod 255
      logic              validate;
      logic              err;
   } fci_fin_type;

   // Reduce a value below 512 to its residue modulo 255
   function automatic logic [BYTE_W-1:0] fold255(input logic [9:0] v);
      logic [9:0] t;
      t = (v >= 10'(MOD_FL)) ? v - 10'(MOD_FL) : v;
      t = (t >= 10'(MOD_FL)) ? t - 10'(MOD_FL) : t;
      return t[BYTE_W-1:0];
   endfunction

endpackage

### rtl/fci_in_reg.sv
// ----------------------------------------------------------------------------
// fci_in_reg
// Input register: captures one word from the request channel and holds it
// until the accumulator takes it.
// ----------------------------------------------------------------------------
module fci_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fci_pkg::fci_item_type req_item,
   input  logic                  take,
   output logic                  item_valid,
   output fci_pkg::fci_item_type item
);

   logic                  valid_ff, valid_in;
   fci_pkg::fci_item_type item_ff;

   // Accept whenever the register is empty or is being drained
   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload on every accepted word
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/fci_accum.sv
// ----------------------------------------------------------------------------
// fci_accum
// Running Fletcher sums, byte position and offset distance; on the last
// byte of a packet it loads a summary record for the check byte stage.
// ----------------------------------------------------------------------------
module fci_accum #(
   parameter int unsigned LENGTH_BITS = fci_pkg::LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  fci_pkg::fci_item_type item,
   output logic                  take,
   input  logic                  fin_take,
   output logic                  fin_valid,
   output fci_pkg::fci_fin_type  fin
);

   // Compare width that holds a position and an offset plus one
   localparam int unsigned CW = (LENGTH_BITS > fci_pkg::OFFSET_W) ? LENGTH_BITS
                                                                  : fci_pkg::OFFSET_W + 1;
   localparam int unsigned BW = fci_pkg::BYTE_W;

   logic                        in_packet_ff, in_packet_in;
   logic [BW-1:0]               sum_first_ff, sum_first_in;
   logic [BW-1:0]               sum_second_ff, sum_second_in;
   logic [LENGTH_BITS-1:0]      byte_count_ff, byte_count_in;
   logic [BW-1:0]               dist_ff, dist_in;
   logic [fci_pkg::OFFSET_W-1:0] latched_offset_ff;
   logic                        latched_validate_ff;
   logic                        fin_valid_ff, fin_valid_in;
   fci_pkg::fci_fin_type        fin_ff, fin_in;

   logic                         first;
   logic [fci_pkg::OFFSET_W-1:0] off;
   logic                         val;
   logic [LENGTH_BITS-1:0]       pos;
   logic [BW-1:0]                s1_prev, s2_prev, dist_cur;
   logic [BW-1:0]                off_mod, data_eff;
   logic [CW-1:0]                pos_x, off_x;
   logic                         at_max, err;

   // Take a byte unless it closes a packet while the summary slot is full
   assign take = item_valid && (!item.last_byte || !fin_valid_ff || fin_take);

   // Select the packet context: fresh on a first byte, latched otherwise
   always_comb begin
      first    = !in_packet_ff;
      off      = first ? item.check_offset  : latched_offset_ff;
      val      = first ? item.validate_only : latched_validate_ff;
      pos      = first ? '0 : byte_count_ff;
      s1_prev  = first ? '0 : sum_first_ff;
      s2_prev  = first ? '0 : sum_second_ff;
      off_mod  = fci_pkg::fold255(10'(off[15:8]) + 10'(off[7:0]));
      dist_cur = first ? ((off_mod == '0) ? '0 : BW'(fci_pkg::MOD_FL) - off_mod)
                       : dist_ff;
      pos_x    = CW'(pos);
      off_x    = CW'(off);
      at_max   = &pos;
      err      = !val && (off_x >= pos_x);
   end

   // Advance the sums, the position and the distance
   always_comb begin
      data_eff      = (!val && (pos_x == off_x || pos_x == off_x + CW'(1)))
                      ? '0 : item.data_byte;
      sum_first_in  = fci_pkg::fold255(10'(s1_prev) + 10'(data_eff));
      sum_second_in = fci_pkg::fold255(10'(s2_prev) + 10'(sum_first_in));
      byte_count_in = at_max ? pos : pos + LENGTH_BITS'(1);
      if (at_max) begin
         dist_in = dist_cur;
      end else begin
         dist_in = (dist_cur == BW'(fci_pkg::MOD_FL - 1)) ? '0 : dist_cur + BW'(1);
      end
      in_packet_in     = !item.last_byte;
      fin_in.sum_first  = sum_first_in;
      fin_in.sum_second = sum_second_in;
      fin_in.span       = dist_cur;
      fin_in.validate   = val;
      fin_in.err        = err;
      fin_valid_in      = (fin_valid_ff && !fin_take) || (take && item.last_byte);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         if (take) begin
            in_packet_ff <= in_packet_in;
         end
      end
   end

   // Running state and packet context
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_first_ff        <= '0;
         sum_second_ff       <= '0;
         byte_count_ff       <= '0;
         dist_ff             <= '0;
         latched_offset_ff   <= '0;
         latched_validate_ff <= 1'b0;
      end else if (take) begin
         sum_first_ff        <= sum_first_in;
         sum_second_ff       <= sum_second_in;
         byte_count_ff       <= byte_count_in;
         dist_ff             <= dist_in;
         latched_offset_ff   <= off;
         latched_validate_ff <= val;
      end
   end

   // Hold the packet summary until the check stage takes it
   always_ff @(posedge clock) begin
      if (take && item.last_byte) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

### rtl/fci_check.sv
// ----------------------------------------------------------------------------
// fci_check
// Check byte stage: works out X and Y from the packet summary and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module fci_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fin_valid,
   input  fci_pkg::fci_fin_type              fin,
   output logic                              fin_take,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fci_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int unsigned BW = fci_pkg::BYTE_W;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [fci_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [15:0]   prod;
   logic [16:0]   xsum;
   logic [BW-1:0] x_mod, x_byte, y_byte, x_out, y_out;
   logic [9:0]    y_raw, y_red;
   logic          sums_zero;

   // Move the summary on when the output register is free or draining
   assign fin_take     = fin_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = fin_take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // X = (k * sum1 - sum2) mod 255 with 0 mapped to 255, Y = -(sum1 + X)
   always_comb begin
      prod   = 16'(fin.span) * 16'(fin.sum_first);
      xsum   = 17'(prod) + 17'(fci_pkg::MOD_FL) - 17'(fin.sum_second);
      x_mod  = fci_pkg::fold255(10'(xsum[7:0]) + 10'(xsum[15:8]) + 10'(xsum[16]));
      x_byte = (x_mod == '0) ? BW'(fci_pkg::MOD_FL) : x_mod;
      y_raw  = 10'(fci_pkg::TWO_MOD) - 10'(fin.sum_first) - 10'(x_byte);
      y_red  = (y_raw > 10'(fci_pkg::MOD_FL)) ? y_raw - 10'(fci_pkg::MOD_FL) : y_raw;
      y_byte = y_red[BW-1:0];
      x_out  = (fin.validate || fin.err) ? '0 : x_byte;
      y_out  = (fin.validate || fin.err) ? '0 : y_byte;
      sums_zero   = (fin.sum_first == '0) && (fin.sum_second == '0);
      rsp_data_in = {6'b0, fin.err, sums_zero, fin.sum_second, fin.sum_first,
                     y_out, x_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/fletcher_checksum_insert.sv
// ----------------------------------------------------------------------------
// fletcher_checksum_insert
// Byte-serial ISO 8473 Fletcher checksum: generates the two check bytes to
// insert at a given offset, or validates a packet and reports its sums.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                      Word
// req      in   req_tvalid/tready/tdata/   one packet byte, tlast on the final
//               tlast/tuser                byte, offset and mode on the first
// rsp      out  rsp_tvalid/tready/tdata    one result per packet
//
// Throughput is one byte per cycle while no final byte is held back: each
// byte costs two modulo-255 adds in the accumulator. A result passes through
// the input register, the accumulator summary register and the output register; the X byte
// multiply sits alone in the output stage. Reset clears all valids and the
// packet state. A stalled rsp holds its word while non-final bytes still flow;
// a final byte waits only when both summary slot and output are full.
// ----------------------------------------------------------------------------
module fletcher_checksum_insert #(
   parameter int unsigned LENGTH_BITS = fci_pkg::LENGTH_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // data_byte[7:0], check_offset[23:8]
   input  logic [fci_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   // validate_only[0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // check_first[7:0], check_second[15:8], raw_sums[31:16], sums_zero[32],
   // offset_error[33], zero fill[39:34]
   output logic [fci_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   fci_pkg::fci_item_type req_item, item;
   fci_pkg::fci_fin_type  fin;
   logic                  item_valid, take, fin_valid, fin_take;

   // Unpack the request word
   always_comb begin
      req_item.data_byte     = req_tdata[7:0];
      req_item.check_offset  = req_tdata[23:8];
      req_item.last_byte     = req_tlast;
      req_item.validate_only = req_tuser;
   end

   fci_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   fci_accum #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .fin_take   (fin_take),
      .fin_valid  (fin_valid),
      .fin        (fin)
   );

   fci_check u_check (
      .clock      (clock),
      .reset      (reset),
      .fin_valid  (fin_valid),
      .fin        (fin),
      .fin_take   (fin_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/fci_checker.sv
// ----------------------------------------------------------------------------
// fci_checker
// Port-level checks on the Fletcher checksum block, bound to its top level.
// ----------------------------------------------------------------------------
module fci_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fci_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // Reset empties the input register, so a word can be taken at once
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

   // An offset error carries zero check bytes
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[15:0] == 16'h0000)
      else $error("check bytes set on offset error");

   // Generated check bytes come as a nonzero pair
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] != 8'h00 |-> rsp_tdata[15:8] != 8'h00
                                             && !rsp_tdata[33])
      else $error("check bytes incomplete");

endmodule

bind fletcher_checksum_insert fci_checker u_fci_checker (.*);
